// ===== sv/jsu_pkg.sv =====
package jsu_pkg;

    // End-of-string status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_TRUNC = 2'd1;
    localparam logic [1:0] ST_FAIL  = 2'd2;

    // One group of output bytes made by one input byte: up to four UTF-8 bytes,
    // or a single end item that carries the status.
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [1:0]      last_idx;
        logic            eos;
        logic [1:0]      status;
    } entry_t;

endpackage

// ===== sv/jsu_front.sv =====
module jsu_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  logic [7:0]      in_byte,
    input  logic            is_last,
    output logic            gen_valid,
    output jsu_pkg::entry_t gen_entry
);

    typedef enum logic [8:0]
    {
        PH_OPEN       = 9'b000000001,
        PH_TEXT       = 9'b000000010,
        PH_ESCAPE     = 9'b000000100,
        PH_HEX_FIRST  = 9'b000001000,
        PH_PAIR_SLASH = 9'b000010000,
        PH_PAIR_U     = 9'b000100000,
        PH_HEX_SECOND = 9'b001000000,
        PH_DONE_OK    = 9'b010000000,
        PH_DONE_FAIL  = 9'b100000000
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [1:0]  hex_cnt_reg;
    logic [1:0]  hex_cnt_next;
    logic [9:0]  first_unit_reg;
    logic [9:0]  first_unit_next;
    logic [15:0] acc_reg;
    logic [15:0] acc_next;

    logic [4:0]  hex_d;
    logic [15:0] acc_shift;
    logic [20:0] pair_cp;

    // Bit 4 set means the byte is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = 5'h10;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            r = {1'b0, 4'(b - 8'h30)};
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            r = {1'b0, 4'(b - 8'h57)};
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            r = {1'b0, 4'(b - 8'h37)};
        end
        return r;
    endfunction

    function automatic jsu_pkg::entry_t utf8_entry(input logic [20:0] cp);
        jsu_pkg::entry_t e;
        e = '0;
        if (cp <= 21'h7F)
        begin
            e.data[0]  = cp[7:0];
            e.last_idx = 2'd0;
        end
        else if (cp <= 21'h7FF)
        begin
            e.data[0]  = {3'b110, cp[10:6]};
            e.data[1]  = {2'b10, cp[5:0]};
            e.last_idx = 2'd1;
        end
        else if (cp <= 21'hFFFF)
        begin
            e.data[0]  = {4'b1110, cp[15:12]};
            e.data[1]  = {2'b10, cp[11:6]};
            e.data[2]  = {2'b10, cp[5:0]};
            e.last_idx = 2'd2;
        end
        else
        begin
            e.data[0]  = {5'b11110, cp[20:18]};
            e.data[1]  = {2'b10, cp[17:12]};
            e.data[2]  = {2'b10, cp[11:6]};
            e.data[3]  = {2'b10, cp[5:0]};
            e.last_idx = 2'd3;
        end
        return e;
    endfunction

    assign hex_d     = hex_value(in_byte);
    assign acc_shift = {acc_reg[11:0], hex_d[3:0]};
    assign pair_cp   = 21'h10000 + {1'b0, first_unit_reg, acc_shift[9:0]};

    always_comb
    begin
        phase_next      = phase_reg;
        hex_cnt_next    = hex_cnt_reg;
        first_unit_next = first_unit_reg;
        acc_next        = acc_reg;
        gen_valid       = 1'b0;
        gen_entry       = '0;

        if (take)
        begin
            if (is_last)
            begin
                gen_valid        = 1'b1;
                gen_entry.eos    = 1'b1;
                unique case (phase_reg) inside
                    PH_OPEN, PH_TEXT, PH_DONE_OK: gen_entry.status = jsu_pkg::ST_OK;
                    PH_ESCAPE:                    gen_entry.status = jsu_pkg::ST_TRUNC;
                    default:                      gen_entry.status = jsu_pkg::ST_FAIL;
                endcase
                phase_next      = PH_OPEN;
                hex_cnt_next    = 2'd0;
                first_unit_next = 10'd0;
                acc_next        = 16'd0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_OPEN:
                    begin
                        phase_next = PH_TEXT;
                    end
                    PH_TEXT:
                    begin
                        if (in_byte == 8'h22)
                        begin
                            phase_next = PH_DONE_OK;
                        end
                        else if (in_byte == 8'h5C)
                        begin
                            phase_next = PH_ESCAPE;
                        end
                        else
                        begin
                            gen_valid         = 1'b1;
                            gen_entry.data[0] = in_byte;
                        end
                    end
                    PH_ESCAPE:
                    begin
                        phase_next = PH_TEXT;
                        gen_valid  = 1'b1;
                        unique case (in_byte) inside
                            8'h22, 8'h2F, 8'h5C: gen_entry.data[0] = in_byte;
                            8'h62:               gen_entry.data[0] = 8'h08;
                            8'h66:               gen_entry.data[0] = 8'h0C;
                            8'h6E:               gen_entry.data[0] = 8'h0A;
                            8'h72:               gen_entry.data[0] = 8'h0D;
                            8'h74:               gen_entry.data[0] = 8'h09;
                            8'h75:
                            begin
                                gen_valid    = 1'b0;
                                phase_next   = PH_HEX_FIRST;
                                hex_cnt_next = 2'd0;
                                acc_next     = 16'd0;
                            end
                            default:
                            begin
                                gen_valid  = 1'b0;
                                phase_next = PH_DONE_FAIL;
                            end
                        endcase
                    end
                    PH_HEX_FIRST, PH_HEX_SECOND:
                    begin
                        if (hex_d[4])
                        begin
                            phase_next = PH_DONE_FAIL;
                        end
                        else
                        begin
                            acc_next     = acc_shift;
                            hex_cnt_next = hex_cnt_reg + 2'd1;
                            if (hex_cnt_reg == 2'd3)
                            begin
                                hex_cnt_next = 2'd0;
                                phase_next   = PH_TEXT;
                                if (phase_reg == PH_HEX_SECOND)
                                begin
                                    gen_valid = 1'b1;
                                    gen_entry = utf8_entry(pair_cp);
                                end
                                else if (acc_shift >= 16'hD800 && acc_shift <= 16'hDBFF)
                                begin
                                    // High surrogate: hold its bits for the pair.
                                    first_unit_next = acc_shift[9:0];
                                    phase_next      = PH_PAIR_SLASH;
                                end
                                else
                                begin
                                    gen_valid = 1'b1;
                                    gen_entry = utf8_entry({5'd0, acc_shift});
                                end
                            end
                        end
                    end
                    PH_PAIR_SLASH:
                    begin
                        phase_next = (in_byte == 8'h5C) ? PH_PAIR_U : PH_DONE_FAIL;
                    end
                    PH_PAIR_U:
                    begin
                        if (in_byte == 8'h75)
                        begin
                            phase_next   = PH_HEX_SECOND;
                            hex_cnt_next = 2'd0;
                            acc_next     = 16'd0;
                        end
                        else
                        begin
                            phase_next = PH_DONE_FAIL;
                        end
                    end
                    PH_DONE_OK:
                    begin
                        phase_next = PH_DONE_OK;
                    end
                    default:
                    begin
                        phase_next = PH_DONE_FAIL;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_OPEN;
            hex_cnt_reg    <= 2'd0;
            first_unit_reg <= 10'd0;
            acc_reg        <= 16'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            hex_cnt_reg    <= hex_cnt_next;
            first_unit_reg <= first_unit_next;
            acc_reg        <= acc_next;
        end
    end

endmodule

// ===== sv/jsu_queue.sv =====
module jsu_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  jsu_pkg::entry_t wr_entry,
    output logic            full,
    input  logic            rd_en,
    output jsu_pkg::entry_t rd_entry,
    output logic            not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jsu_pkg::entry_t mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_entry  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/jsu_back.sv =====
module jsu_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_not_empty,
    input  jsu_pkg::entry_t q_entry,
    output logic            q_pop,
    input  logic            pop,
    output logic            empty,
    output logic [7:0]      out_byte,
    output logic            end_of_string,
    output logic [1:0]      status
);

    jsu_pkg::entry_t work_reg;
    logic            work_valid_reg;
    logic [1:0]      idx_reg;
    logic            out_valid_reg;
    logic [7:0]      out_byte_reg;
    logic            out_eos_reg;
    logic [1:0]      out_status_reg;

    logic            advance;
    logic            work_done;

    assign advance   = work_valid_reg && (!out_valid_reg || pop);
    assign work_done = advance && (idx_reg == work_reg.last_idx);
    assign q_pop     = q_not_empty && (!work_valid_reg || work_done);

    assign empty         = !out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign end_of_string = out_eos_reg;
    assign status        = out_status_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            work_reg <= q_entry;
        end
        if (advance)
        begin
            out_byte_reg   <= work_reg.data[idx_reg];
            out_eos_reg    <= work_reg.eos;
            out_status_reg <= work_reg.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            idx_reg        <= 2'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                work_valid_reg <= 1'b1;
                idx_reg        <= 2'd0;
            end
            else if (work_done)
            begin
                work_valid_reg <= 1'b0;
            end
            else if (advance)
            begin
                idx_reg <= idx_reg + 2'd1;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== sv/json_string_unescape_utf8_unit.sv =====
// Throughput: one input byte per cycle while full is low; results leave at
// one byte per cycle while pop is high, one result per UTF-8 byte.
// Reset: rst_n is asynchronous and active low; it empties the queue and the
// output stage and returns the decoder to waiting for an opening byte.
module json_string_unescape_utf8_unit
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       is_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       end_of_string,
    output logic [1:0] status
);

    // The front decoder classifies each byte of the token and turns it into a
    // group of zero to four output bytes. Groups wait in a short queue, and the
    // back end sends them out one byte per cycle of pop through a registered
    // output. Because escapes shrink the text, a four-byte group always comes
    // from at least twelve input bytes, so the queue rarely fills at full rate.

    logic            take;
    logic            gen_valid;
    jsu_pkg::entry_t gen_entry;
    logic            q_not_empty;
    jsu_pkg::entry_t q_entry;
    logic            q_pop;

    // A request is taken whenever the queue has room, whether or not the byte
    // makes any output.
    assign take = push && !full;

    jsu_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .in_byte   (in_byte),
        .is_last   (is_last),
        .gen_valid (gen_valid),
        .gen_entry (gen_entry)
    );

    jsu_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (gen_valid),
        .wr_entry  (gen_entry),
        .full      (full),
        .rd_en     (q_pop),
        .rd_entry  (q_entry),
        .not_empty (q_not_empty)
    );

    jsu_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_entry       (q_entry),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .out_byte      (out_byte),
        .end_of_string (end_of_string),
        .status        (status)
    );

endmodule

// ===== tb/sv/json_string_unescape_utf8_unit_tb.sv =====
module json_string_unescape_utf8_unit_tb;

    // ------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------

    // The slowest correct run has over 320 input bytes, at most four
    // output bytes each, with the receiver idling more than half the
    // time in one phase plus one long hold-off. The limit is far above
    // that, so it only ends a run where the block has hung.
    localparam int CYCLE_LIMIT   = 200000;
    // The drain wait gives the block time to show a stray result.
    localparam int DRAIN_CYCLES  = 16;
    // Number of cycles the receiver refuses results in the pressure test.
    localparam int HOLD_OFF_LEN  = 120;
    // Minimum input bytes queued for each of the three random phases.
    localparam int PHASE_ITEMS   = 100;

    // Characters that the decoder treats specially.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    // Control characters that the simple escapes stand for.
    localparam logic [7:0] CTRL_BS = 8'h08;
    localparam logic [7:0] CTRL_FF = 8'h0C;
    localparam logic [7:0] CTRL_LF = 8'h0A;
    localparam logic [7:0] CTRL_CR = 8'h0D;
    localparam logic [7:0] CTRL_HT = 8'h09;

    // Value returned by the hex digit decoder for a byte that is no digit.
    localparam logic [4:0] NOT_HEX = 5'd16;

    // Decoder phases, kept in the same order as the block's own encoding.
    typedef enum logic [3:0] {
        DEC_OPEN,
        DEC_TEXT,
        DEC_ESCAPE,
        DEC_HEX_FIRST,
        DEC_PAIR_SLASH,
        DEC_PAIR_U,
        DEC_HEX_SECOND,
        DEC_DONE_OK,
        DEC_DONE_FAIL
    } dec_phase_t;

    // One input request: a raw byte of the string token.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } token_byte_t;

    // One result: a UTF-8 byte, or the end item that carries the status.
    typedef struct packed {
        logic [7:0] data;
        logic       eos;
        logic [1:0] status;
    } utf8_result_t;

    // ------------------------------------------------------------------
    // Signals of the block. Every input starts at a known value.
    // ------------------------------------------------------------------

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] in_byte = 8'h00;
    logic       is_last = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] out_byte;
    logic       end_of_string;
    logic [1:0] status;

    json_string_unescape_utf8_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .in_byte       (in_byte),
        .is_last       (is_last),
        .empty         (empty),
        .pop           (pop),
        .out_byte      (out_byte),
        .end_of_string (end_of_string),
        .status        (status)
    );

    // ------------------------------------------------------------------
    // Testbench state
    // ------------------------------------------------------------------

    token_byte_t  pending_requests[$];   // bytes waiting to be offered
    utf8_result_t expected_utf8[$];      // results the block still owes

    token_byte_t  next_request;
    utf8_result_t wanted;

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int items_accepted    = 0;
    int queued_items      = 0;
    int mismatch_count    = 0;
    int cycle_count       = 0;
    int hold_arm_at       = -1;
    int hold_left         = 0;
    bit hold_used         = 1'b0;

    // Shadow copy of the decoder state, advanced once per accepted request.
    dec_phase_t  dec_phase   = DEC_OPEN;
    logic [1:0]  hex_count   = 2'd0;
    logic [9:0]  high_bits   = 10'd0;
    logic [15:0] code_unit   = 16'd0;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Prediction of the decoder
    // ------------------------------------------------------------------

    // Value of an ASCII hex digit, or NOT_HEX for any other byte.
    function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return {1'b0, c[3:0]};
        if (c >= "a" && c <= "f")
            return 5'(c - "a" + 8'd10);
        if (c >= "A" && c <= "F")
            return 5'(c - "A" + 8'd10);
        return NOT_HEX;
    endfunction

    task automatic expect_byte(input logic [7:0] b);
        expected_utf8.push_back('{data: b, eos: 1'b0, status: jsu_pkg::ST_OK});
    endtask

    // Splits a code point into its UTF-8 bytes, one to four of them.
    task automatic expect_code_point(input logic [20:0] cp);
        if (cp <= 21'h7F)
        begin
            expect_byte(cp[7:0]);
        end
        else if (cp <= 21'h7FF)
        begin
            expect_byte({3'b110, cp[10:6]});
            expect_byte({2'b10, cp[5:0]});
        end
        else if (cp <= 21'hFFFF)
        begin
            expect_byte({4'b1110, cp[15:12]});
            expect_byte({2'b10, cp[11:6]});
            expect_byte({2'b10, cp[5:0]});
        end
        else
        begin
            // Joined pairs never exceed 0x10FFFF, so this is the last case.
            expect_byte({5'b11110, cp[20:18]});
            expect_byte({2'b10, cp[17:12]});
            expect_byte({2'b10, cp[11:6]});
            expect_byte({2'b10, cp[5:0]});
        end
    endtask

    // Advances the shadow decoder by one byte and queues what it emits.
    task automatic predict_unescape(input logic [7:0] b, input logic last);
        logic [4:0]  digit;
        logic        unit_done;
        logic [1:0]  end_status;
        logic [20:0] joined;

        digit     = hex_digit_value(b);
        unit_done = 1'b0;

        if (last)
        begin
            // The closing byte is never decoded; it reports how the
            // token ended and returns the decoder to its reset state.
            case (dec_phase)
                DEC_OPEN, DEC_TEXT, DEC_DONE_OK: end_status = jsu_pkg::ST_OK;
                DEC_ESCAPE:                      end_status = jsu_pkg::ST_TRUNC;
                default:                         end_status = jsu_pkg::ST_FAIL;
            endcase
            expected_utf8.push_back('{data: 8'h00, eos: 1'b1, status: end_status});
            dec_phase = DEC_OPEN;
            hex_count = 2'd0;
            high_bits = 10'd0;
            code_unit = 16'd0;
            return;
        end

        // Both hex phases collect four digits the same way.
        if ((dec_phase == DEC_HEX_FIRST || dec_phase == DEC_HEX_SECOND) &&
            digit != NOT_HEX)
        begin
            code_unit = {code_unit[11:0], digit[3:0]};
            if (hex_count == 2'd3)
            begin
                hex_count = 2'd0;
                unit_done = 1'b1;
            end
            else
            begin
                hex_count = hex_count + 2'd1;
            end
        end

        case (dec_phase)
            DEC_OPEN:
            begin
                dec_phase = DEC_TEXT;
            end
            DEC_TEXT:
            begin
                if (b == CH_QUOTE)
                    dec_phase = DEC_DONE_OK;
                else if (b == CH_BSLASH)
                    dec_phase = DEC_ESCAPE;
                else
                    expect_byte(b);
            end
            DEC_ESCAPE:
            begin
                dec_phase = DEC_TEXT;
                case (b)
                    CH_QUOTE, CH_SLASH, CH_BSLASH: expect_byte(b);
                    CH_B: expect_byte(CTRL_BS);
                    CH_F: expect_byte(CTRL_FF);
                    CH_N: expect_byte(CTRL_LF);
                    CH_R: expect_byte(CTRL_CR);
                    CH_T: expect_byte(CTRL_HT);
                    CH_U:
                    begin
                        dec_phase = DEC_HEX_FIRST;
                        hex_count = 2'd0;
                        code_unit = 16'd0;
                    end
                    default: dec_phase = DEC_DONE_FAIL;
                endcase
            end
            DEC_HEX_FIRST:
            begin
                if (digit == NOT_HEX)
                begin
                    dec_phase = DEC_DONE_FAIL;
                end
                else if (unit_done)
                begin
                    if (code_unit >= 16'hD800 && code_unit <= 16'hDBFF)
                    begin
                        high_bits = code_unit[9:0];
                        dec_phase = DEC_PAIR_SLASH;
                    end
                    else
                    begin
                        expect_code_point({5'd0, code_unit});
                        dec_phase = DEC_TEXT;
                    end
                end
            end
            DEC_PAIR_SLASH:
            begin
                dec_phase = (b == CH_BSLASH) ? DEC_PAIR_U : DEC_DONE_FAIL;
            end
            DEC_PAIR_U:
            begin
                if (b == CH_U)
                begin
                    dec_phase = DEC_HEX_SECOND;
                    hex_count = 2'd0;
                    code_unit = 16'd0;
                end
                else
                begin
                    dec_phase = DEC_DONE_FAIL;
                end
            end
            DEC_HEX_SECOND:
            begin
                if (digit == NOT_HEX)
                begin
                    dec_phase = DEC_DONE_FAIL;
                end
                else if (unit_done)
                begin
                    // The second unit is not range-checked; only its low
                    // ten bits take part in the supplementary code point.
                    joined = 21'h10000 + {1'b0, high_bits, code_unit[9:0]};
                    expect_code_point(joined);
                    dec_phase = DEC_TEXT;
                end
            end
            DEC_DONE_OK:
            begin
                // After an unescaped quote every byte is ignored.
            end
            default:
            begin
                dec_phase = DEC_DONE_FAIL;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driver: offers pending bytes, with random gaps between requests.
    // A request stays on the ports until the block takes it.
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push    <= 1'b0;
            in_byte <= 8'h00;
            is_last <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_unescape(in_byte, is_last);
                items_accepted <= items_accepted + 1;
            end
            if (!push || !full)
            begin
                if (pending_requests.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct)
                begin
                    next_request = pending_requests.pop_front();
                    push    <= 1'b1;
                    in_byte <= next_request.data;
                    is_last <= next_request.last;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver hold-off. Once armed, it keeps pop low for a long stretch
    // while the driver goes on offering bytes, so the block fills up and
    // has to raise full.
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (!hold_used && items_accepted == hold_arm_at)
        begin
            hold_left <= HOLD_OFF_LEN;
            hold_used <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes results at random and checks each one against the
    // oldest expected result, field by field.
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_utf8.size() == 0)
                begin
                    $error("result with nothing expected: out_byte=%h end_of_string=%b status=%0d",
                           out_byte, end_of_string, status);
                    mismatch_count++;
                end
                else
                begin
                    wanted = expected_utf8.pop_front();
                    if (out_byte !== wanted.data)
                    begin
                        $error("out_byte: expected %h, actual %h", wanted.data, out_byte);
                        mismatch_count++;
                    end
                    if (end_of_string !== wanted.eos)
                    begin
                        $error("end_of_string: expected %b, actual %b",
                               wanted.eos, end_of_string);
                        mismatch_count++;
                    end
                    if (status !== wanted.status)
                    begin
                        $error("status: expected %0d, actual %0d", wanted.status, status);
                        mismatch_count++;
                    end
                end
            end
            pop <= (hold_left == 0) && ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus building blocks
    // ------------------------------------------------------------------

    task automatic queue_byte(input logic [7:0] b, input logic last = 1'b0);
        pending_requests.push_back('{data: b, last: last});
        queued_items++;
    endtask

    // The opening and closing positions are never decoded, so any byte
    // may stand there.
    task automatic queue_open();
        queue_byte(8'($urandom_range(255)));
    endtask

    task automatic queue_close();
        queue_byte(8'($urandom_range(255)), 1'b1);
    endtask

    // A hex digit for a nibble, letters in random case.
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return "0" + 8'(n);
        if ($urandom_range(1) == 0)
            return "a" + 8'(n) - 8'd10;
        return "A" + 8'(n) - 8'd10;
    endfunction

    // A \uXXXX escape carrying the given code unit.
    task automatic queue_unit(input logic [15:0] v);
        queue_byte(CH_BSLASH);
        queue_byte(CH_U);
        queue_byte(hex_char(v[15:12]));
        queue_byte(hex_char(v[11:8]));
        queue_byte(hex_char(v[7:4]));
        queue_byte(hex_char(v[3:0]));
    endtask

    // Picks from a range, landing on either bound now and then.
    function automatic logic [15:0] pick_unit(input logic [15:0] lo, input logic [15:0] hi);
        int r;
        r = $urandom_range(7);
        if (r == 0)
            return lo;
        if (r == 1)
            return hi;
        return 16'($urandom_range(hi, lo));
    endfunction

    // A plain text byte: anything but the quote and the backslash.
    task automatic queue_text_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CH_QUOTE || b == CH_BSLASH);
        queue_byte(b);
    endtask

    task automatic queue_simple_escape();
        logic [7:0] letters [8];
        letters = '{CH_QUOTE, CH_SLASH, CH_BSLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
        queue_byte(CH_BSLASH);
        queue_byte(letters[$urandom_range(7)]);
    endtask

    // A single code unit of one, two or three UTF-8 bytes, or a lone
    // low surrogate, which the block encodes as three bytes.
    task automatic queue_single_unit();
        logic [15:0] v;
        case ($urandom_range(3))
            0: v = pick_unit(16'h0000, 16'h007F);
            1: v = pick_unit(16'h0080, 16'h07FF);
            2:
            begin
                do
                    v = pick_unit(16'h0800, 16'hFFFF);
                while (v >= 16'hD800 && v <= 16'hDBFF);
            end
            default: v = pick_unit(16'hDC00, 16'hDFFF);
        endcase
        queue_unit(v);
    endtask

    // A high surrogate followed by a second unit. The second unit is
    // mostly a proper low surrogate but sometimes any value at all.
    task automatic queue_pair();
        queue_unit(pick_unit(16'hD800, 16'hDBFF));
        if ($urandom_range(4) != 0)
            queue_unit(pick_unit(16'hDC00, 16'hDFFF));
        else
            queue_unit(16'($urandom_range(16'hFFFF)));
    endtask

    // Pieces that end decoding early: a bad escape letter, a bad hex
    // digit, a malformed pair or an unescaped quote.
    task automatic queue_broken_piece();
        logic [7:0] b;
        int         k;
        case ($urandom_range(4))
            0:
            begin
                do
                    b = 8'($urandom_range(255));
                while (b inside {CH_QUOTE, CH_SLASH, CH_BSLASH, CH_B, CH_F,
                                 CH_N, CH_R, CH_T, CH_U});
                queue_byte(CH_BSLASH);
                queue_byte(b);
            end
            1:
            begin
                queue_byte(CH_BSLASH);
                queue_byte(CH_U);
                k = $urandom_range(3);
                repeat (k)
                    queue_byte(hex_char(4'($urandom_range(15))));
                do
                    b = 8'($urandom_range(255));
                while (hex_digit_value(b) != NOT_HEX);
                queue_byte(b);
            end
            2:
            begin
                // High surrogate with something other than a backslash.
                queue_unit(pick_unit(16'hD800, 16'hDBFF));
                do
                    b = 8'($urandom_range(255));
                while (b == CH_BSLASH);
                queue_byte(b);
            end
            3:
            begin
                // High surrogate, backslash, then something other than u.
                queue_unit(pick_unit(16'hD800, 16'hDBFF));
                queue_byte(CH_BSLASH);
                do
                    b = 8'($urandom_range(255));
                while (b == CH_U);
                queue_byte(b);
            end
            default:
            begin
                queue_byte(CH_QUOTE);
            end
        endcase
    endtask

    // A whole token: opening byte, a few pieces, an optional unfinished
    // tail, and the closing byte. Most tokens are well formed.
    task automatic queue_random_token();
        int pieces;
        int kind;
        int k;
        queue_open();
        pieces = $urandom_range(6);
        repeat (pieces)
        begin
            kind = $urandom_range(99);
            if (kind < 35)
                queue_text_byte();
            else if (kind < 55)
                queue_simple_escape();
            else if (kind < 78)
                queue_single_unit();
            else if (kind < 92)
                queue_pair();
            else
                queue_broken_piece();
        end
        case ($urandom_range(11))
            0: queue_byte(CH_BSLASH);           // escape cut off by the close
            1:
            begin
                // \u escape cut off before its fourth digit.
                queue_byte(CH_BSLASH);
                queue_byte(CH_U);
                k = $urandom_range(3);
                repeat (k)
                    queue_byte(hex_char(4'($urandom_range(15))));
            end
            2: queue_unit(pick_unit(16'hD800, 16'hDBFF));  // pair left open
            default: ;
        endcase
        queue_close();
    endtask

    task automatic queue_random_phase();
        int start;
        start = queued_items;
        while (queued_items - start < PHASE_ITEMS)
            queue_random_token();
    endtask

    // Waits until every byte has been taken and every result checked.
    task automatic wait_drained();
        while (pending_requests.size() != 0 || push || expected_utf8.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        // Reset is held at the start and never again.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed tokens, with neither side idling.
        // An empty token: the closing flag comes on the opening byte.
        queue_byte(CH_QUOTE, 1'b1);
        // Extreme text bytes, a simple escape, then an unescaped quote
        // after which a byte is ignored.
        queue_open();
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(CH_BSLASH);
        queue_byte(CH_N);
        queue_byte(CH_QUOTE);
        queue_byte(CH_U);
        queue_close();
        // The highest code point, a four-byte sequence.
        queue_open();
        queue_unit(16'hDBFF);
        queue_unit(16'hDFFF);
        queue_close();
        // A backslash right before the close.
        queue_open();
        queue_byte(CH_BSLASH);
        queue_close();
        wait_drained();

        // Sender idles often, receiver idles more.
        sender_idle_pct   = 35;
        receiver_idle_pct = 58;
        queue_random_phase();
        wait_drained();

        // The other way round.
        sender_idle_pct   = 58;
        receiver_idle_pct = 35;
        queue_random_phase();
        wait_drained();

        // No idling at all, with one long receiver hold-off early on so
        // the block backs up against a sender that never pauses.
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_arm_at       = items_accepted + 6;
        queue_random_phase();
        wait_drained();

        if (mismatch_count == 0 && expected_utf8.size() == 0)
            $display("json_string_unescape_utf8_unit_tb: PASS");
        else
            $display("json_string_unescape_utf8_unit_tb: FAIL");
        $finish;
    end

    // Watchdog: a hung block ends the run here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("json_string_unescape_utf8_unit_tb: FAIL");
        $finish;
    end

endmodule
